// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the command frame responder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define HCFR_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define HCFR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hcfr_pkg.sv =====
// Shared types and constants of the host command frame responder.
package hcfr_pkg;

   // Protocol bytes.
   localparam logic [7:0] BYTE_SYNC     = 8'hA5;
   localparam logic [7:0] BYTE_HEADER   = 8'h5A;
   localparam logic [7:0] BYTE_DIGEST   = 8'h70;
   localparam logic [7:0] BYTE_CONFIRM  = 8'h71;
   localparam logic [7:0] BYTE_QUERY    = 8'h88;
   localparam logic [7:0] BYTE_DISP_ID  = 8'h89;
   localparam logic [7:0] SUB_DIGEST    = 8'h00;
   localparam logic [7:0] SUB_CONFIRM   = 8'h01;
   localparam logic [7:0] SUM_SEED      = 8'hFF;  // 0x5A + 0xA5

   localparam int FRAME_LEN   = 8;
   localparam int POS_W       = $clog2(FRAME_LEN);
   localparam int DIGEST_MAX  = 32;
   localparam int DIGEST_WORDS = 4;
   localparam int DISPLAY_LEN = 8;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGEST0      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGEST1      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGEST2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGEST3      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_TYPE = 3'd4;

   // Reply classes handed from the frame collector to the reply sequencer.
   typedef enum logic [1:0] {
      CMD_DIGEST  = 2'd0,
      CMD_CONFIRM = 2'd1,
      CMD_SELECT  = 2'd2,
      CMD_DISPLAY = 2'd3
   } cmd_type;

   // One result word.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       select_host_port;
      logic       request_update;
      logic       last;
   } rsp_word_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/host_command_frame_responder.sv =====
// Top level of the host command frame responder: registers, collector, queue, sequencer.
//
// The block takes one received byte per cycle on the req_ channel and gathers bytes
// into 8-byte frames; a byte of 0xA5 always restarts a frame at position 0. When the
// eighth byte arrives the frame collector classifies it in the same cycle and, if it
// calls for a reply, pushes one command into a two-entry queue. The reply sequencer
// drains that queue and sends one result word per cycle while rsp_ready lets the output
// register move, on the rsp_ channel; a digest reply has min(DIGEST_BYTES, 32) + 3 words
// (35 at the default), a display query 8 words and a select or confirm frame one word.
// Input bytes flow at one per cycle whenever the queue has room; the collector stalls
// only while both queue entries hold commands that the sequencer has not yet started,
// which with steady output back-pressure or long digest replies sets the sustained
// input rate. Configuration writes on the csr_ port take effect in the next cycle and
// must be made while no reply is pending. There is no clearing pass after reset; the
// block is ready in the first cycle after reset is released.
`include "assert_macros.svh"

module host_command_frame_responder #(
   parameter int DIGEST_BYTES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_tx_byte,
   output logic                               rsp_tx_valid,
   output logic                               rsp_select_host_port,
   output logic                               rsp_request_update,
   output logic                               rsp_last,
   input  logic                               csr_we,
   input  logic [hcfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hcfr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hcfr_pkg::*;

   // Configuration registers: the digest words and the display type code.
   logic [DIGEST_WORDS-1:0][63:0] digest_ff, digest_in;
   logic [7:0]                    display_type_ff, display_type_in;

   always_comb begin
      digest_in       = digest_ff;
      display_type_in = display_type_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DIGEST0:      digest_in[0]    = csr_wdata;
            CSR_DIGEST1:      digest_in[1]    = csr_wdata;
            CSR_DIGEST2:      digest_in[2]    = csr_wdata;
            CSR_DIGEST3:      digest_in[3]    = csr_wdata;
            CSR_DISPLAY_TYPE: display_type_in = csr_wdata[7:0];
            default:          ;  // Writes to unused indexes are dropped.
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digest_ff       <= '0;
         display_type_ff <= '0;
      end else begin
         digest_ff       <= digest_in;
         display_type_ff <= display_type_in;
      end
   end

   // Front: frame collection and classification.
   queue_status_type q_status;
   logic             push_valid;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          head_cmd;
   rsp_word_type     rsp_word;

   hcfr_frame_rx u_frame_rx (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   // The queue decouples frame intake from the reply stream.
   hcfr_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .status     (q_status)
   );

   // Back: reply word generation with the output register.
   hcfr_reply_seq #(
      .DIGEST_BYTES (DIGEST_BYTES)
   ) u_reply_seq (
      .clock        (clock),
      .reset        (reset),
      .digest       (digest_ff),
      .display_type (display_type_ff),
      .q_status     (q_status),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word)
   );

   assign rsp_tx_byte          = rsp_word.tx_byte;
   assign rsp_tx_valid         = rsp_word.tx_valid;
   assign rsp_select_host_port = rsp_word.select_host_port;
   assign rsp_request_update   = rsp_word.request_update;
   assign rsp_last             = rsp_word.last;

   // A frame can only complete while the queue has room, since intake stalls when full.
   `HCFR_ASSERT_RST(a_ready_tracks_queue, clock, reset, req_ready == !q_status.full, "intake ready disagrees with queue space")

endmodule

// ===== rtl/hcfr_frame_rx.sv =====
// Frame collector: gathers received bytes into frames and classifies them.
`include "assert_macros.svh"

module hcfr_frame_rx (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   input  hcfr_pkg::queue_status_type q_status,
   output logic                      push_valid,
   output hcfr_pkg::cmd_type         push_cmd
);
   import hcfr_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in, eff_pos;
   logic [7:0]       b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic             accept, frame_end, hit;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   // A sync byte always lands at position 0.
   assign eff_pos   = (req_rx_byte == BYTE_SYNC) ? '0 : pos_ff;
   assign frame_end = (eff_pos == POS_W'(FRAME_LEN - 1));

   always_comb begin
      pos_in = pos_ff;
      b1_in  = b1_ff;
      b2_in  = b2_ff;
      b3_in  = b3_ff;
      if (accept) begin
         pos_in = frame_end ? '0 : eff_pos + POS_W'(1);
         if (eff_pos == POS_W'(1)) b1_in = req_rx_byte;
         if (eff_pos == POS_W'(2)) b2_in = req_rx_byte;
         if (eff_pos == POS_W'(3)) b3_in = req_rx_byte;
      end
   end

   // Byte 7 is the incoming byte itself; bytes 4 to 6 never matter.
   always_comb begin
      hit      = 1'b0;
      push_cmd = CMD_SELECT;
      if (b1_ff == BYTE_HEADER && b2_ff == BYTE_DIGEST) begin
         hit = 1'b1;
         if (b3_ff == SUB_DIGEST && req_rx_byte == BYTE_DIGEST) begin
            push_cmd = CMD_DIGEST;
         end else if (b3_ff == SUB_CONFIRM && req_rx_byte == BYTE_CONFIRM) begin
            push_cmd = CMD_CONFIRM;
         end
      end else if (b1_ff == BYTE_HEADER && b2_ff == BYTE_QUERY &&
                   b3_ff == SUB_DIGEST && req_rx_byte == BYTE_QUERY) begin
         hit      = 1'b1;
         push_cmd = CMD_DISPLAY;
      end
   end

   assign push_valid = accept && frame_end && hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      b3_ff <= b3_in;
   end

endmodule

// ===== rtl/hcfr_cmd_queue.sv =====
// Two-entry queue of decoded commands between the collector and the sequencer.
`include "assert_macros.svh"

module hcfr_cmd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  hcfr_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output hcfr_pkg::cmd_type          head_cmd,
   output hcfr_pkg::queue_status_type status
);
   import hcfr_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   `HCFR_ASSERT_RST(a_no_push_when_full, clock, reset, !(push_valid && status.full), "command pushed into a full queue")
   `HCFR_ASSERT_RST(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `HCFR_ASSERT_RST(a_pop_moves_head, clock, reset, (do_pop && !do_push && count_ff == CNT_W'(1)) |=> status.empty, "queue not empty after draining last entry")

endmodule

// ===== rtl/hcfr_reply_seq.sv =====
// Reply sequencer: turns queued commands into result words, one per cycle unless rsp_ready holds the output.
`include "assert_macros.svh"

module hcfr_reply_seq #(
   parameter int DIGEST_BYTES = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [hcfr_pkg::DIGEST_WORDS-1:0][63:0] digest,
   input  logic [7:0]                             display_type,
   input  hcfr_pkg::queue_status_type             q_status,
   input  hcfr_pkg::cmd_type                      head_cmd,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output hcfr_pkg::rsp_word_type                 rsp_word
);
   import hcfr_pkg::*;

   localparam int DIG_N   = (DIGEST_BYTES < DIGEST_MAX) ? DIGEST_BYTES : DIGEST_MAX;
   localparam int CNT_W   = $clog2(DIG_N + 3);
   localparam int DIG_W   = $clog2(DIGEST_MAX);
   localparam logic [CNT_W-1:0] SUM_IDX  = CNT_W'(DIG_N + 2);
   localparam logic [CNT_W-1:0] DISP_END = CNT_W'(DISPLAY_LEN - 1);

   logic [DIGEST_MAX-1:0][7:0] dig_bytes;
   logic [DIG_W-1:0]           dig_idx;
   logic [7:0]                 dig_byte;

   logic             cur_valid_ff, cur_valid_in;
   cmd_type          cur_cmd_ff, cur_cmd_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   logic             out_valid_ff, out_valid_in;
   rsp_word_type     out_ff, out_in;
   rsp_word_type     word;
   logic             out_load, cur_done, in_digest_data;

   assign dig_bytes = digest;
   assign dig_idx   = DIG_W'(idx_ff - CNT_W'(2));
   assign dig_byte  = dig_bytes[dig_idx];
   assign in_digest_data = (cur_cmd_ff == CMD_DIGEST) && (idx_ff >= CNT_W'(2)) &&
                           (idx_ff < SUM_IDX);

   // Word for the current command at the current step.
   always_comb begin
      word = '0;
      unique case (cur_cmd_ff)
         CMD_DIGEST: begin
            word.tx_valid = 1'b1;
            if (idx_ff == '0) begin
               word.tx_byte          = BYTE_HEADER;
               word.select_host_port = 1'b1;
            end else if (idx_ff == CNT_W'(1)) begin
               word.tx_byte = BYTE_SYNC;
            end else if (idx_ff == SUM_IDX) begin
               word.tx_byte = sum_ff;
               word.last    = 1'b1;
            end else begin
               word.tx_byte = dig_byte;
            end
         end
         CMD_CONFIRM: begin
            word.select_host_port = 1'b1;
            word.request_update   = 1'b1;
            word.last             = 1'b1;
         end
         CMD_SELECT: begin
            word.select_host_port = 1'b1;
            word.last             = 1'b1;
         end
         CMD_DISPLAY: begin
            word.tx_valid = 1'b1;
            case (idx_ff[2:0])
               3'd0:    word.tx_byte = BYTE_SYNC;
               3'd1:    word.tx_byte = BYTE_HEADER;
               3'd2:    word.tx_byte = BYTE_DISP_ID;
               3'd3:    word.tx_byte = display_type;
               3'd7:    word.tx_byte = BYTE_DISP_ID + display_type;
               default: word.tx_byte = 8'h00;
            endcase
            word.last = (idx_ff == DISP_END);
         end
         default: word = '0;
      endcase
   end

   assign out_load = cur_valid_ff && (!out_valid_ff || rsp_ready);
   assign cur_done = out_load && word.last;
   assign pop      = !q_status.empty && (!cur_valid_ff || cur_done);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_cmd_in   = cur_cmd_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_cmd_in   = head_cmd;
         idx_in       = '0;
         sum_in       = SUM_SEED;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end else if (out_load) begin
         idx_in = idx_ff + CNT_W'(1);
         if (in_digest_data) sum_in = sum_ff + dig_byte;
      end
      out_valid_in = out_load ? 1'b1 : (out_valid_ff && !rsp_ready);
      out_in       = out_load ? word : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      cur_cmd_ff <= cur_cmd_in;
      sum_ff     <= sum_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   `HCFR_ASSERT_RST(a_quiet_word_alone, clock, reset, (out_valid_ff && !out_ff.tx_valid) |-> (out_ff.last && out_ff.select_host_port && out_ff.tx_byte == 8'h00), "non-transmit word is not a lone select word")
   `HCFR_ASSERT_RST(a_step_bound, clock, reset, cur_valid_ff |-> (idx_ff <= SUM_IDX), "reply step past the end of the digest reply")
   `HCFR_ASSERT_RST(a_reset_idle, clock, reset, $past(reset) |-> (!out_valid_ff && !cur_valid_ff), "sequencer busy right after reset")

endmodule

// ===== tb/host_command_frame_responder_checker.sv =====
// Reply predictor and result checker for the host command frame responder.
module host_command_frame_responder_checker #(
   parameter int DIGEST_BYTES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [7:0]                      rsp_tx_byte,
   input  logic                            rsp_tx_valid,
   input  logic                            rsp_select_host_port,
   input  logic                            rsp_request_update,
   input  logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [hcfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hcfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatch_count,
   output int                              replies_pending
);
   import hcfr_pkg::*;

   logic [63:0]      digest_words [DIGEST_WORDS];
   logic [7:0]       display_code;
   logic [7:0]       frame_bytes [FRAME_LEN];
   logic [POS_W-1:0] frame_pos;
   rsp_word_type     reply_words_due [$];

   function automatic void queue_reply_word(logic [7:0] tx_byte, logic tx_valid,
                                            logic select_host, logic update,
                                            logic last_word);
      rsp_word_type word;
      word.tx_byte          = tx_valid ? tx_byte : 8'h00;
      word.tx_valid         = tx_valid;
      word.select_host_port = select_host;
      word.request_update   = update;
      word.last             = last_word;
      reply_words_due.push_back(word);
   endfunction

   // Stores one received byte and, when it completes a frame, queues the reply words.
   function automatic void decode_rx_byte(logic [7:0] rx);
      logic [7:0] digest_sum;
      logic [7:0] digest_byte;
      int         sent;
      if (rx == BYTE_SYNC)
         frame_pos = '0;
      frame_bytes[frame_pos] = rx;
      if (frame_pos != POS_W'(FRAME_LEN - 1)) begin
         frame_pos = frame_pos + 1'b1;
         return;
      end
      frame_pos = '0;

      if (frame_bytes[1] == BYTE_HEADER && frame_bytes[2] == BYTE_DIGEST) begin
         if (frame_bytes[3] == SUB_DIGEST && frame_bytes[7] == BYTE_DIGEST) begin
            digest_sum = SUM_SEED;
            queue_reply_word(BYTE_HEADER, 1'b1, 1'b1, 1'b0, 1'b0);
            queue_reply_word(BYTE_SYNC, 1'b1, 1'b0, 1'b0, 1'b0);
            sent = 0;
            while (sent < DIGEST_BYTES && sent < DIGEST_MAX) begin
               digest_byte = digest_words[sent / 8][8 * (sent % 8) +: 8];
               digest_sum  = digest_sum + digest_byte;
               queue_reply_word(digest_byte, 1'b1, 1'b0, 1'b0, 1'b0);
               sent++;
            end
            queue_reply_word(digest_sum, 1'b1, 1'b0, 1'b0, 1'b1);
         end else if (frame_bytes[3] == SUB_CONFIRM && frame_bytes[7] == BYTE_CONFIRM) begin
            queue_reply_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
         end else begin
            queue_reply_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
         end
      end else if (frame_bytes[1] == BYTE_HEADER && frame_bytes[2] == BYTE_QUERY &&
                   frame_bytes[3] == SUB_DIGEST && frame_bytes[7] == BYTE_QUERY) begin
         queue_reply_word(BYTE_SYNC, 1'b1, 1'b0, 1'b0, 1'b0);
         queue_reply_word(BYTE_HEADER, 1'b1, 1'b0, 1'b0, 1'b0);
         queue_reply_word(BYTE_DISP_ID, 1'b1, 1'b0, 1'b0, 1'b0);
         queue_reply_word(display_code, 1'b1, 1'b0, 1'b0, 1'b0);
         queue_reply_word(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
         queue_reply_word(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
         queue_reply_word(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
         queue_reply_word(BYTE_DISP_ID + display_code, 1'b1, 1'b0, 1'b0, 1'b1);
      end
   endfunction

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_reply_word();
      rsp_word_type want;
      if (reply_words_due.size() == 0) begin
         $error("unexpected reply word: tx_byte %0h tx_valid %0b", rsp_tx_byte, rsp_tx_valid);
         mismatch_count++;
         return;
      end
      want = reply_words_due.pop_front();
      compare_field("tx_byte", want.tx_byte, rsp_tx_byte);
      compare_field("tx_valid", 8'(want.tx_valid), 8'(rsp_tx_valid));
      compare_field("select_host_port", 8'(want.select_host_port),
                    8'(rsp_select_host_port));
      compare_field("request_update", 8'(want.request_update), 8'(rsp_request_update));
      compare_field("last", 8'(want.last), 8'(rsp_last));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < DIGEST_WORDS; w++)
            digest_words[w] = '0;
         display_code   = '0;
         frame_pos      = '0;
         mismatch_count = 0;
         reply_words_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DIGEST0:      digest_words[0] = csr_wdata;
               CSR_DIGEST1:      digest_words[1] = csr_wdata;
               CSR_DIGEST2:      digest_words[2] = csr_wdata;
               CSR_DIGEST3:      digest_words[3] = csr_wdata;
               CSR_DISPLAY_TYPE: display_code    = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            decode_rx_byte(req_rx_byte);
         if (rsp_valid && rsp_ready)
            check_reply_word();
      end
      replies_pending = reply_words_due.size();
   end

endmodule

// ===== tb/host_command_frame_responder_tb.sv =====
// Testbench top for the host command frame responder: clock, reset, stimulus and verdict.
module host_command_frame_responder_tb;
   import hcfr_pkg::*;

   localparam int DIGEST_BYTES = 32;

   // Every block input holds a known value from time zero.
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_rx_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_tx_byte;
   logic                  rsp_tx_valid;
   logic                  rsp_select_host_port;
   logic                  rsp_request_update;
   logic                  rsp_last;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int replies_pending;
   int bytes_sent = 0;

   // Handshake between the stimulus and the reply drain for the long hold-off.
   bit start_backlog  = 1'b0;
   bit backlog_active = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   host_command_frame_responder #(
      .DIGEST_BYTES(DIGEST_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_select_host_port(rsp_select_host_port),
      .rsp_request_update(rsp_request_update),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   host_command_frame_responder_checker #(
      .DIGEST_BYTES(DIGEST_BYTES)
   ) reply_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_select_host_port(rsp_select_host_port),
      .rsp_request_update(rsp_request_update),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .replies_pending(replies_pending)
   );

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 88)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // A random payload byte that never restarts the frame.
   function automatic logic [7:0] rand_data_byte();
      logic [7:0] value;
      do
         value = 8'($urandom_range(0, 255));
      while (value == BYTE_SYNC);
      return value;
   endfunction

   // Offers one word on the request channel and returns at the falling edge after
   // it is taken. Valid is only dropped when a gap is asked for, so it never gets a
   // low and a high in the same time step.
   task automatic send_rx_byte(input logic [7:0] value, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Writes all five registers on consecutive cycles, holding the write enable high.
   task automatic load_settings(input logic [255:0] digest, input logic [7:0] code);
      csr_we    <= 1'b1;
      csr_index <= CSR_DIGEST0;
      csr_wdata <= digest[63:0];
      @(negedge clock);
      csr_index <= CSR_DIGEST1;
      csr_wdata <= digest[127:64];
      @(negedge clock);
      csr_index <= CSR_DIGEST2;
      csr_wdata <= digest[191:128];
      @(negedge clock);
      csr_index <= CSR_DIGEST3;
      csr_wdata <= digest[255:192];
      @(negedge clock);
      csr_index <= CSR_DISPLAY_TYPE;
      csr_wdata <= {56'd0, code};
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_random_settings();
      logic [255:0] digest;
      for (int i = 0; i < 8; i++)
         digest[32 * i +: 32] = $urandom;
      load_settings(digest, 8'($urandom_range(0, 255)));
   endtask

   // Stops offering words and lets every outstanding reply drain. The extra cycles
   // cover anything still moving through the output register before a register write.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (replies_pending != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Sends one frame. Most are well formed with random payload bytes; the rest are
   // near misses, pure noise, or frames cut short so that a later sync byte has to
   // pull the collector back to position 0. An eager frame is always a digest request
   // sent without gaps, which is what piles up work behind a stalled receiver.
   task automatic send_random_frame(input bit eager);
      logic [7:0] frame [FRAME_LEN];
      int         kind;
      int         frame_len;
      kind      = $urandom_range(0, 99);
      frame_len = FRAME_LEN;
      frame[0]  = ($urandom_range(0, 99) < 85) ? BYTE_SYNC : rand_data_byte();
      frame[1]  = BYTE_HEADER;
      frame[2]  = BYTE_DIGEST;
      frame[3]  = SUB_DIGEST;
      for (int i = 4; i < 7; i++)
         frame[i] = rand_data_byte();
      frame[7]  = BYTE_DIGEST;
      if (eager || kind < 25) begin
         // Digest request as built above.
      end else if (kind < 38) begin
         frame[3] = SUB_CONFIRM;
         frame[7] = BYTE_CONFIRM;
      end else if (kind < 50) begin
         // Host link frame with a sub-byte or tail that may not match either reply.
         frame[3] = 8'($urandom_range(0, 2));
         frame[7] = $urandom_range(0, 1) ? BYTE_CONFIRM : rand_data_byte();
      end else if (kind < 66) begin
         frame[2] = BYTE_QUERY;
         frame[7] = BYTE_QUERY;
      end else if (kind < 76) begin
         frame[2] = BYTE_QUERY;
         frame[3] = $urandom_range(0, 1) ? SUB_CONFIRM : SUB_DIGEST;
         case ($urandom_range(0, 2))
            0:       frame[7] = BYTE_QUERY;
            1:       frame[7] = BYTE_DISP_ID;
            default: frame[7] = rand_data_byte();
         endcase
      end else if (kind < 88) begin
         for (int i = 0; i < FRAME_LEN; i++)
            frame[i] = 8'($urandom_range(0, 255));
      end else begin
         frame_len = $urandom_range(1, FRAME_LEN - 1);
      end
      for (int i = 0; i < frame_len; i++)
         send_rx_byte(frame[i], eager ? 0 : pick_gap());
   endtask

   // Reply drain: ready runs of random length, broken by random stalls. Once the
   // stimulus asks for it, one long stall lets the block fill up and hold off input.
   initial begin : reply_drain
      int  run_len;
      int  gap_len;
      bit  backlog_done;
      backlog_done = 1'b0;
      @(negedge clock);
      forever begin
         run_len = $urandom_range(1, 24);
         rsp_ready <= 1'b1;
         repeat (run_len) @(negedge clock);
         if (start_backlog && !backlog_done) begin
            gap_len        = 400;
            backlog_done   = 1'b1;
            backlog_active = 1'b1;
         end else begin
            gap_len = pick_gap();
         end
         if (gap_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len) @(negedge clock);
         end
         backlog_active = 1'b0;
      end
   end

   initial begin : stimulus
      logic [7:0] opening_bytes [25];

      // Digest request with an unchecked first byte of zero, then a display query
      // whose frame is restarted by a sync byte, then a confirm frame.
      opening_bytes = '{8'h00, BYTE_HEADER, BYTE_DIGEST, SUB_DIGEST,
                        8'hFF, 8'h00, 8'h80, BYTE_DIGEST,
                        8'h7F, BYTE_SYNC, BYTE_HEADER, BYTE_QUERY, SUB_DIGEST,
                        8'h01, 8'hFE, 8'h00, BYTE_QUERY,
                        BYTE_SYNC, BYTE_HEADER, BYTE_DIGEST, SUB_CONFIRM,
                        8'h55, 8'hAA, 8'h00, BYTE_CONFIRM};

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // All-zero settings: the digest sum reduces to the seed alone.
      load_settings('0, 8'h00);
      foreach (opening_bytes[i])
         send_rx_byte(opening_bytes[i], pick_gap());
      drain_replies();

      // All-ones settings: every digest byte and the display code at their maximum.
      load_settings('1, 8'hFF);
      while (bytes_sent < 100)
         send_random_frame(1'b0);
      drain_replies();

      // Random settings with a burst of digest requests against a stalled receiver.
      load_random_settings();
      start_backlog = 1'b1;
      wait (backlog_active);
      repeat (6) send_random_frame(1'b1);
      while (bytes_sent < 170)
         send_random_frame(1'b0);
      drain_replies();

      load_random_settings();
      while (bytes_sent < 232)
         send_random_frame(1'b0);
      drain_replies();

      if (mismatch_count == 0 && replies_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
